// ----- design/pund_pkg.sv -----
// Shared constants, types and conversion functions for the pixel unpack / downscale block.
`default_nettype none

package pund_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W = $clog2(MAX_DIM) + 1;   // holds 1..MAX_DIM
    localparam int POS_W = $clog2(MAX_DIM);       // holds 0..MAX_DIM-1
    localparam int WANT_W = 13;                   // wanted position wraps within 13 bits
    localparam int LAYOUT_W = 12;
    localparam int PIXEL_W = 32;
    localparam int CHAN_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_LAYOUT    = 3'd0,
        REG_GREEN_LAYOUT  = 3'd1,
        REG_BLUE_LAYOUT   = 3'd2,
        REG_SOURCE_WIDTH  = 3'd3,
        REG_SOURCE_HEIGHT = 3'd4,
        REG_TARGET_WIDTH  = 3'd5,
        REG_TARGET_HEIGHT = 3'd6
    } cfg_reg_t;

    // clamped frame sizes
    typedef struct packed {
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
    } dims_t;

    // integer part and remainder of the source/target ratios
    typedef struct packed {
        logic [DIM_W-1:0] col_q;
        logic [DIM_W-1:0] col_r;
        logic [DIM_W-1:0] row_q;
        logic [DIM_W-1:0] row_r;
    } steps_t;

    typedef struct packed {
        logic emit;
        logic last;
    } scan_out_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // wanted += q, rem += m, carry when rem reaches tgt
    function automatic logic [2*WANT_W-1:0] step_wanted(input logic [WANT_W-1:0] wanted,
                                                        input logic [WANT_W-1:0] rem,
                                                        input logic [DIM_W-1:0] q,
                                                        input logic [DIM_W-1:0] m,
                                                        input logic [DIM_W-1:0] tgt);
        logic [WANT_W:0] r;
        logic [WANT_W-1:0] w;
        r = {1'b0, rem} + (WANT_W+1)'(m);
        w = wanted + WANT_W'(q);
        if (r >= (WANT_W+1)'(tgt)) begin
            r = r - (WANT_W+1)'(tgt);
            w = w + WANT_W'(1);
        end
        return {w, r[WANT_W-1:0]};
    endfunction

    // mask by offset/length, then align the field's top bits to an 8-bit channel
    function automatic logic [CHAN_W-1:0] channel_of(input logic [PIXEL_W-1:0] pixel,
                                                     input logic [LAYOUT_W-1:0] layout);
        logic [5:0] off;
        logic [5:0] len;
        logic [6:0] total;
        logic [6:0] shr;
        logic [3:0] shl;
        logic [PIXEL_W-1:0] v;
        logic [PIXEL_W-1:0] sv;
        off = layout[5:0];
        len = layout[11:6];
        total = {1'b0, off} + {1'b0, len};
        for (int i = 0; i < PIXEL_W; i++) begin
            v[i] = pixel[i] && (7'(i) >= {1'b0, off}) && (7'(i) < total);
        end
        if (total >= 7'(CHAN_W)) begin
            shr = total - 7'(CHAN_W);
            if (shr >= 7'(PIXEL_W)) begin
                sv = '0;
            end else begin
                sv = v >> shr[4:0];
            end
        end else begin
            shl = 4'(7'(CHAN_W) - total);
            sv = v << shl;
        end
        return sv[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/pixel_unpack_nearest_downscale.sv -----
// Top level: pixel unpack and nearest-neighbor downscale.
`default_nettype none

// Takes raw framebuffer words in raster order, one per clock while s_tready is high,
// and emits an RGB888 word for each output position whose nearest source pixel is
// the current one. A word passes through an input register and a result register
// before its result is on m_tvalid/m_tdata, and a new word is taken every cycle
// while the result side keeps up and no ratio recompute runs. The size ratios come
// from two 13-step serial dividers: after reset and after a write to a size
// register, s_tready stays low while they run; a size write that lands during
// a run starts one more run once that one ends. Input tuser marks the first word
// of a source frame; m_tlast marks the last word of the output frame.
module pixel_unpack_nearest_downscale (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pund_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pund_pkg::CFG_DATA_W-1:0]   cfg_data,
    // source pixels
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // [31:0] pixel_word
    input  wire logic                              s_tuser,  // [0] frame_start
    // output pixels
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [23:0]                            m_tdata,  // [7:0] red_byte,
                                                             // [15:8] green_byte,
                                                             // [23:16] blue_byte
    output logic                                   m_tlast   // frame_last
);

    localparam int DIM_W = pund_pkg::DIM_W;
    localparam int LAYOUT_W = pund_pkg::LAYOUT_W;
    localparam int CHAN_W = pund_pkg::CHAN_W;

    logic [LAYOUT_W-1:0] red_layout_reg, green_layout_reg, blue_layout_reg;
    logic [DIM_W-1:0]    src_width_reg, src_height_reg, tgt_width_reg, tgt_height_reg;
    logic                dirty_reg;
    pund_pkg::dims_t     dims_reg, dims_next;
    pund_pkg::steps_t    steps;
    logic [DIM_W-1:0]    col_q, col_r, row_q, row_r;
    logic                col_busy, row_busy, div_busy, div_start, cfg_write, size_write;

    logic                           s1_valid_reg, s1_valid_next;
    logic [pund_pkg::PIXEL_W-1:0]   s1_pixel_reg;
    logic                           s1_start_reg;
    logic                           accept, advance;

    pund_pkg::scan_out_t  scan_status;
    logic [CHAN_W-1:0]    red_byte, green_byte, blue_byte;

    logic                 m_valid_reg, m_valid_next;
    logic [23:0]          m_data_reg;
    logic                 m_last_reg;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        size_write = 1'b0;
        case (pund_pkg::cfg_reg_t'(cfg_index))
            pund_pkg::REG_SOURCE_WIDTH,
            pund_pkg::REG_SOURCE_HEIGHT,
            pund_pkg::REG_TARGET_WIDTH,
            pund_pkg::REG_TARGET_HEIGHT: size_write = cfg_write;
            default: size_write = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_layout_reg <= LAYOUT_W'(651);
            green_layout_reg <= LAYOUT_W'(389);
            blue_layout_reg <= LAYOUT_W'(320);
            src_width_reg <= DIM_W'(640);
            src_height_reg <= DIM_W'(480);
            tgt_width_reg <= DIM_W'(640);
            tgt_height_reg <= DIM_W'(480);
        end else if (cfg_write) begin
            case (pund_pkg::cfg_reg_t'(cfg_index))
                pund_pkg::REG_RED_LAYOUT:    red_layout_reg <= cfg_data[LAYOUT_W-1:0];
                pund_pkg::REG_GREEN_LAYOUT:  green_layout_reg <= cfg_data[LAYOUT_W-1:0];
                pund_pkg::REG_BLUE_LAYOUT:   blue_layout_reg <= cfg_data[LAYOUT_W-1:0];
                pund_pkg::REG_SOURCE_WIDTH:  src_width_reg <= cfg_data[DIM_W-1:0];
                pund_pkg::REG_SOURCE_HEIGHT: src_height_reg <= cfg_data[DIM_W-1:0];
                pund_pkg::REG_TARGET_WIDTH:  tgt_width_reg <= cfg_data[DIM_W-1:0];
                pund_pkg::REG_TARGET_HEIGHT: tgt_height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // size clamping and ratio recompute
    always_comb begin
        dims_next.sw = pund_pkg::clamp_dim(src_width_reg, DIM_W'(pund_pkg::MAX_DIM));
        dims_next.sh = pund_pkg::clamp_dim(src_height_reg, DIM_W'(pund_pkg::MAX_DIM));
        dims_next.tw = pund_pkg::clamp_dim(tgt_width_reg, dims_next.sw);
        dims_next.th = pund_pkg::clamp_dim(tgt_height_reg, dims_next.sh);
    end

    assign div_busy = col_busy || row_busy;
    assign div_start = dirty_reg && !div_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= 1'b1;
        end else begin
            dirty_reg <= size_write || (dirty_reg && div_busy);
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            dims_reg <= dims_next;
        end
    end

    pund_divider u_col_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dims_next.sw),
        .divisor   (dims_next.tw),
        .busy      (col_busy),
        .quotient  (col_q),
        .remainder (col_r)
    );

    pund_divider u_row_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dims_next.sh),
        .divisor   (dims_next.th),
        .busy      (row_busy),
        .quotient  (row_q),
        .remainder (row_r)
    );

    assign steps = {col_q, col_r, row_q, row_r};

    // input register
    assign advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !dirty_reg && !div_busy && (!s1_valid_reg || advance);
    assign accept = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= s_tdata;
            s1_start_reg <= s_tuser;
        end
    end

    pund_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .frame_start (s1_start_reg),
        .dims        (dims_reg),
        .steps       (steps),
        .status      (scan_status)
    );

    pund_unpack u_unpack (
        .pixel        (s1_pixel_reg),
        .red_layout   (red_layout_reg),
        .green_layout (green_layout_reg),
        .blue_layout  (blue_layout_reg),
        .red_byte     (red_byte),
        .green_byte   (green_byte),
        .blue_byte    (blue_byte)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = scan_status.emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && scan_status.emit) begin
            m_data_reg <= {blue_byte, green_byte, red_byte};
            m_last_reg <= scan_status.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

`ifndef SYNTHESIS
    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> !s_tready)
        else $error("input word taken while size ratios recompute");

    a_result_not_overwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !advance)
        else $error("stalled result word overwritten");

    a_stage_fill_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s1_valid_reg) |-> $past(s_tvalid && s_tready))
        else $error("input register filled without a handshake");
`endif

endmodule

`default_nettype wire

// ----- design/pund_divider.sv -----
// Bit-serial restoring divider for the source/target size ratios.
`default_nettype none

module pund_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [pund_pkg::DIM_W-1:0] dividend,
    input  wire logic [pund_pkg::DIM_W-1:0] divisor,
    output logic                            busy,
    output logic [pund_pkg::DIM_W-1:0]      quotient,
    output logic [pund_pkg::DIM_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(pund_pkg::DIM_W + 1);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [pund_pkg::DIM_W-1:0] quo_reg, quo_next;
    logic [pund_pkg::DIM_W-1:0] rem_reg, rem_next;
    logic [pund_pkg::DIM_W-1:0] den_reg, den_next;
    logic [pund_pkg::DIM_W:0]   trial;
    logic [pund_pkg::DIM_W:0]   diff;
    logic                       fits;

    always_comb begin
        trial = {rem_reg, quo_reg[pund_pkg::DIM_W-1]};
        diff = trial - {1'b0, den_reg};
        fits = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(pund_pkg::DIM_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[pund_pkg::DIM_W-2:0], fits};
            rem_next = fits ? diff[pund_pkg::DIM_W-1:0] : trial[pund_pkg::DIM_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- design/pund_scan.sv -----
// Source/output position counters and nearest-neighbor selection.
`default_nettype none

module pund_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire logic               frame_start,
    input  wire pund_pkg::dims_t    dims,
    input  wire pund_pkg::steps_t   steps,
    output pund_pkg::scan_out_t     status
);

    localparam int POS_W = pund_pkg::POS_W;
    localparam int WANT_W = pund_pkg::WANT_W;
    localparam int DIM_W = pund_pkg::DIM_W;

    logic [POS_W-1:0]  src_col_reg, src_col_next;
    logic [POS_W-1:0]  src_row_reg, src_row_next;
    logic [POS_W-1:0]  out_col_reg, out_col_next;
    logic [POS_W-1:0]  out_row_reg, out_row_next;
    logic [WANT_W-1:0] want_col_reg, want_col_next;
    logic [WANT_W-1:0] col_rem_reg, col_rem_next;
    logic [WANT_W-1:0] want_row_reg, want_row_next;
    logic [WANT_W-1:0] row_rem_reg, row_rem_next;

    logic [POS_W-1:0]  src_col, src_row, out_col, out_row;
    logic [WANT_W-1:0] want_col, col_rem, want_row, row_rem;
    logic              col_hit, row_hit;
    logic [2*WANT_W-1:0] col_step, row_step;

    always_comb begin
        // frame start clears everything before this pixel is looked at
        src_col = frame_start ? '0 : src_col_reg;
        src_row = frame_start ? '0 : src_row_reg;
        out_col = frame_start ? '0 : out_col_reg;
        out_row = frame_start ? '0 : out_row_reg;
        want_col = frame_start ? '0 : want_col_reg;
        col_rem = frame_start ? '0 : col_rem_reg;
        want_row = frame_start ? '0 : want_row_reg;
        row_rem = frame_start ? '0 : row_rem_reg;

        col_hit = (WANT_W'(src_col) == want_col) && (DIM_W'(out_col) < dims.tw);
        row_hit = (WANT_W'(src_row) == want_row) && (DIM_W'(out_row) < dims.th);

        status.emit = col_hit && row_hit;
        status.last = (DIM_W'(out_row) == dims.th - DIM_W'(1))
                   && (DIM_W'(out_col) == dims.tw - DIM_W'(1));

        col_step = pund_pkg::step_wanted(want_col, col_rem, steps.col_q, steps.col_r, dims.tw);
        row_step = pund_pkg::step_wanted(want_row, row_rem, steps.row_q, steps.row_r, dims.th);

        src_col_next = src_col;
        src_row_next = src_row;
        out_col_next = out_col;
        out_row_next = out_row;
        want_col_next = want_col;
        col_rem_next = col_rem;
        want_row_next = want_row;
        row_rem_next = row_rem;

        if (col_hit) begin
            out_col_next = out_col + POS_W'(1);
            want_col_next = col_step[2*WANT_W-1:WANT_W];
            col_rem_next = col_step[WANT_W-1:0];
        end

        if (DIM_W'(src_col) >= dims.sw - DIM_W'(1)) begin
            src_col_next = '0;
            out_col_next = '0;
            want_col_next = '0;
            col_rem_next = '0;
            if (row_hit) begin
                out_row_next = out_row + POS_W'(1);
                want_row_next = row_step[2*WANT_W-1:WANT_W];
                row_rem_next = row_step[WANT_W-1:0];
            end
            if (DIM_W'(src_row) >= dims.sh - DIM_W'(1)) begin
                // end of source frame: start over by itself
                src_row_next = '0;
                out_row_next = '0;
                want_row_next = '0;
                row_rem_next = '0;
            end else begin
                src_row_next = src_row + POS_W'(1);
            end
        end else begin
            src_col_next = src_col + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            want_col_reg <= '0;
            col_rem_reg <= '0;
            want_row_reg <= '0;
            row_rem_reg <= '0;
        end else if (advance) begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            want_col_reg <= want_col_next;
            col_rem_reg <= col_rem_next;
            want_row_reg <= want_row_next;
            row_rem_reg <= row_rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/pund_unpack.sv -----
// Extracts the three RGB888 channels from a raw pixel word.
`default_nettype none

module pund_unpack (
    input  wire logic [pund_pkg::PIXEL_W-1:0]  pixel,
    input  wire logic [pund_pkg::LAYOUT_W-1:0] red_layout,
    input  wire logic [pund_pkg::LAYOUT_W-1:0] green_layout,
    input  wire logic [pund_pkg::LAYOUT_W-1:0] blue_layout,
    output logic [pund_pkg::CHAN_W-1:0]        red_byte,
    output logic [pund_pkg::CHAN_W-1:0]        green_byte,
    output logic [pund_pkg::CHAN_W-1:0]        blue_byte
);

    assign red_byte = pund_pkg::channel_of(pixel, red_layout);
    assign green_byte = pund_pkg::channel_of(pixel, green_layout);
    assign blue_byte = pund_pkg::channel_of(pixel, blue_layout);

endmodule

`default_nettype wire
